[hw/rtl/khr_pkg.sv]
// khr_pkg: shared constants, types and command codes for the key history ring
// used by khr_ctrl, khr_dp and key_history_ring_with_ref_groups_unit
// no dependencies
`default_nettype none

package khr_pkg;

  // ring depths and derived widths
  localparam int KEY_DEPTH = 32;
  localparam int REF_DEPTH = 64;
  localparam int KEY_AW    = $clog2(KEY_DEPTH);
  localparam int KEY_CW    = $clog2(KEY_DEPTH + 1);
  localparam int REF_AW    = $clog2(REF_DEPTH);
  localparam int REF_CW    = $clog2(REF_DEPTH + 1);

  // fixed field widths
  localparam int CMD_W     = 3;
  localparam int CODE_W    = 8;
  localparam int FLAG_W    = 8;
  localparam int POS_W     = 7;
  localparam int KEY_LEN_W = 6;
  localparam int REF_LEN_W = 7;

  // stored values
  localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [CODE_W-1:0] SEPARATOR  = 8'h00;

  // register indexes
  localparam logic REG_KEY_LEN = 1'b0;
  localparam logic REG_REF_LEN = 1'b1;

  typedef logic [KEY_AW-1:0]        key_addr_t;
  typedef logic [KEY_CW-1:0]        key_cnt_t;
  typedef logic [KEY_CW:0]          key_sum_t;
  typedef logic [REF_AW-1:0]        ref_addr_t;
  typedef logic [REF_CW-1:0]        ref_cnt_t;
  typedef logic [REF_CW:0]          ref_sum_t;
  typedef logic [CODE_W-1:0]        code_t;
  typedef logic [FLAG_W-1:0]        flags_t;
  typedef logic [POS_W-1:0]         upos_t;
  typedef logic signed [POS_W:0]    pos_ext_t;
  typedef logic [FLAG_W+CODE_W-1:0] key_word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESET    = 3'd0,
    CMD_PUSH_KEY = 3'd1,
    CMD_POP_KEY  = 3'd2,
    CMD_PUSH_REF = 3'd3,
    CMD_READ_KEY = 3'd4,
    CMD_READ_REF = 3'd5,
    CMD_ADVANCE  = 3'd6
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic init;
    logic accept;
    logic exec;
    logic read_done;
    logic pop_step;
    logic adv_step;
    logic load_out;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic go_read;
    logic go_pop_walk;
    logic go_adv_walk;
    logic walk_done;
  } stat_t;

endpackage

`default_nettype wire

[hw/rtl/key_history_ring_with_ref_groups_unit.sv]
// key_history_ring_with_ref_groups_unit: top level with the register port
// depends on khr_pkg, khr_ctrl, khr_dp
`default_nettype none

// Key history ring with per-key reference groups. One command is taken per
// transfer and gives exactly one result transfer. Push, reset and unknown
// commands, pop with one key or fewer and advance from a negative position go
// from the exec state straight to the done state; reads pass the read state.
// Other pops and advances walk the reference ring one entry per cycle through
// its single read port, stepping over at most the reference ring length, 64
// entries. A result that is ready while the previous one still waits on the
// output holds the block until that one is taken. A new command may be
// accepted while the previous result still waits on the output. After reset
// and after every register write the block rewrites the first entry of both
// rings in its init state before it takes a command; register writes must
// only come while the block is idle.
module key_history_ring_with_ref_groups_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [khr_pkg::CMD_W-1:0]         command_i,
  input  wire logic [khr_pkg::CODE_W-1:0]        code_in_i,
  input  wire logic [khr_pkg::FLAG_W-1:0]        flags_in_i,
  input  wire logic signed [khr_pkg::POS_W-1:0]  position_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   hit_o,
  output logic [khr_pkg::CODE_W-1:0]             code_out_o,
  output logic [khr_pkg::FLAG_W-1:0]             flags_out_o,
  output logic [khr_pkg::POS_W-1:0]              next_position_o,
  output logic [khr_pkg::KEY_CW-1:0]             keys_held_o,
  output logic [khr_pkg::REF_CW-1:0]             refs_held_o,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic [khr_pkg::KEY_LEN_W-1:0] key_len_q;
  logic [khr_pkg::REF_LEN_W-1:0] ref_len_q;
  logic                          cfg_we;
  khr_pkg::ctrl_t                ctrl;
  khr_pkg::stat_t                stat;

  // register write and read back
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    if (paddr[2] == khr_pkg::REG_REF_LEN) begin
      prdata = 32'(ref_len_q);
    end else begin
      prdata = 32'(key_len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= khr_pkg::KEY_LEN_W'(32);
      ref_len_q <= khr_pkg::REF_LEN_W'(64);
    end else if (cfg_we) begin
      if (paddr[2] == khr_pkg::REG_KEY_LEN) begin
        key_len_q <= pwdata[khr_pkg::KEY_LEN_W-1:0];
      end else begin
        ref_len_q <= pwdata[khr_pkg::REF_LEN_W-1:0];
      end
    end
  end

  khr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  khr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .command_i       (command_i),
    .code_in_i       (code_in_i),
    .flags_in_i      (flags_in_i),
    .position_i      (position_i),
    .key_len_reg_i   (key_len_q),
    .ref_len_reg_i   (ref_len_q),
    .hit_o           (hit_o),
    .code_out_o      (code_out_o),
    .flags_out_o     (flags_out_o),
    .next_position_o (next_position_o),
    .keys_held_o     (keys_held_o),
    .refs_held_o     (refs_held_o)
  );

endmodule

`default_nettype wire

[hw/rtl/khr_ctrl.sv]
// khr_ctrl: sequencing state machine for the key history ring
// depends on khr_pkg (ctrl_t, stat_t)
`default_nettype none

module khr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire logic           cfg_we_i,
  input  wire khr_pkg::stat_t stat_i,
  output khr_pkg::ctrl_t      ctrl_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_POP_WALK,
    ST_ADV_WALK,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // command decode from state
  always_comb begin
    ctrl_o   = '0;
    out_free = !out_valid_q || out_ready_i;
    case (state_q)
      ST_INIT:     ctrl_o.init      = 1'b1;
      ST_IDLE:     ctrl_o.accept    = in_valid_i;
      ST_EXEC:     ctrl_o.exec      = 1'b1;
      ST_READ:     ctrl_o.read_done = 1'b1;
      ST_POP_WALK: ctrl_o.pop_step  = 1'b1;
      ST_ADV_WALK: ctrl_o.adv_step  = 1'b1;
      ST_DONE:     ctrl_o.load_out  = out_free;
      default:     ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: state_q <= ST_IDLE;
        ST_IDLE: begin
          if (ctrl_o.accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (stat_i.go_read) begin
            state_q <= ST_READ;
          end else if (stat_i.go_pop_walk) begin
            state_q <= ST_POP_WALK;
          end else if (stat_i.go_adv_walk) begin
            state_q <= ST_ADV_WALK;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_READ: state_q <= ST_DONE;
        ST_POP_WALK, ST_ADV_WALK: begin
          if (stat_i.walk_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ctrl_o.load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_INIT;
      endcase
      // a register write clears both rings
      if (cfg_we_i) begin
        state_q <= ST_INIT;
      end
    end
  end

`ifndef SYNTH
  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> $past(state_q) == ST_IDLE && $past(in_valid_i))
    else $error("exec entered without an accepted transfer");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && !out_ready_i && !cfg_we_i |=> state_q == ST_DONE)
    else $error("finished result dropped while output stalled");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("output valid raised outside done state");
`endif

endmodule

`default_nettype wire

[hw/rtl/khr_dp.sv]
// khr_dp: ring pointers, counts, key and reference memories, result registers
// depends on khr_pkg; driven by khr_ctrl commands
`default_nettype none

module khr_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire khr_pkg::ctrl_t                      ctrl_i,
  output khr_pkg::stat_t                           stat_o,
  input  wire logic [khr_pkg::CMD_W-1:0]           command_i,
  input  wire logic [khr_pkg::CODE_W-1:0]          code_in_i,
  input  wire logic [khr_pkg::FLAG_W-1:0]          flags_in_i,
  input  wire logic signed [khr_pkg::POS_W-1:0]    position_i,
  input  wire logic [khr_pkg::KEY_LEN_W-1:0]       key_len_reg_i,
  input  wire logic [khr_pkg::REF_LEN_W-1:0]       ref_len_reg_i,
  output logic                                     hit_o,
  output logic [khr_pkg::CODE_W-1:0]               code_out_o,
  output logic [khr_pkg::FLAG_W-1:0]               flags_out_o,
  output logic [khr_pkg::POS_W-1:0]                next_position_o,
  output logic [khr_pkg::KEY_CW-1:0]               keys_held_o,
  output logic [khr_pkg::REF_CW-1:0]               refs_held_o
);

  // memories
  khr_pkg::key_word_t key_mem [khr_pkg::KEY_DEPTH];
  khr_pkg::code_t     ref_mem [khr_pkg::REF_DEPTH];

  // latched item
  logic [khr_pkg::CMD_W-1:0]        command_q;
  khr_pkg::code_t                   code_q;
  khr_pkg::flags_t                  flags_q;
  logic signed [khr_pkg::POS_W-1:0] pos_q;

  // ring state
  khr_pkg::key_addr_t key_newest_q, key_newest_d;
  khr_pkg::key_cnt_t  key_count_q, key_count_d;
  khr_pkg::ref_addr_t ref_newest_q, ref_newest_d;
  khr_pkg::ref_cnt_t  ref_count_q, ref_count_d;

  // advance walk
  khr_pkg::upos_t     adv_idx_q, adv_idx_d;
  khr_pkg::ref_addr_t adv_slot_q, adv_slot_d;

  // pending result
  logic               res_hit_q, res_hit_d;
  khr_pkg::code_t     res_code_q, res_code_d;
  khr_pkg::flags_t    res_flags_q, res_flags_d;
  khr_pkg::upos_t     res_next_q, res_next_d;

  // memory ports
  logic               key_we;
  khr_pkg::key_addr_t key_waddr, key_raddr;
  khr_pkg::key_word_t key_wdata, key_rd_q;
  logic               ref_we;
  khr_pkg::ref_addr_t ref_waddr, ref_raddr;
  khr_pkg::code_t     ref_wdata, ref_rd_q;

  // derived values
  khr_pkg::key_cnt_t  key_len;
  khr_pkg::ref_cnt_t  ref_len;
  khr_pkg::key_addr_t key_push_newest, key_back_newest, key_slot;
  khr_pkg::key_cnt_t  key_push_count;
  khr_pkg::ref_addr_t ref_push_newest, ref_back_newest, ref_slot, adv_slot_dec;
  khr_pkg::ref_cnt_t  ref_push_count;
  khr_pkg::pos_ext_t  key_p;
  khr_pkg::key_sum_t  key_sum;
  khr_pkg::ref_sum_t  ref_sum;
  logic               key_hit, ref_in, adv_inside, pos_neg;
  khr_pkg::upos_t     adv_idx_inc;

  // ring lengths clamped to 1..depth
  always_comb begin
    if (key_len_reg_i == '0) begin
      key_len = khr_pkg::key_cnt_t'(1);
    end else if (khr_pkg::key_sum_t'(key_len_reg_i) > khr_pkg::key_sum_t'(khr_pkg::KEY_DEPTH)) begin
      key_len = khr_pkg::key_cnt_t'(khr_pkg::KEY_DEPTH);
    end else begin
      key_len = khr_pkg::key_cnt_t'(key_len_reg_i);
    end
    if (ref_len_reg_i == '0) begin
      ref_len = khr_pkg::ref_cnt_t'(1);
    end else if (khr_pkg::ref_sum_t'(ref_len_reg_i) > khr_pkg::ref_sum_t'(khr_pkg::REF_DEPTH)) begin
      ref_len = khr_pkg::ref_cnt_t'(khr_pkg::REF_DEPTH);
    end else begin
      ref_len = khr_pkg::ref_cnt_t'(ref_len_reg_i);
    end
  end

  // pointer steps with wrap at the ring length
  always_comb begin
    if (khr_pkg::key_cnt_t'(key_newest_q) + khr_pkg::key_cnt_t'(1) >= key_len) begin
      key_push_newest = '0;
    end else begin
      key_push_newest = key_newest_q + khr_pkg::key_addr_t'(1);
    end
    key_back_newest = (key_newest_q == '0) ? khr_pkg::key_addr_t'(key_len - khr_pkg::key_cnt_t'(1))
                                           : key_newest_q - khr_pkg::key_addr_t'(1);
    key_push_count  = (key_count_q < key_len) ? key_count_q + khr_pkg::key_cnt_t'(1) : key_count_q;

    if (khr_pkg::ref_cnt_t'(ref_newest_q) + khr_pkg::ref_cnt_t'(1) >= ref_len) begin
      ref_push_newest = '0;
    end else begin
      ref_push_newest = ref_newest_q + khr_pkg::ref_addr_t'(1);
    end
    ref_back_newest = (ref_newest_q == '0) ? khr_pkg::ref_addr_t'(ref_len - khr_pkg::ref_cnt_t'(1))
                                           : ref_newest_q - khr_pkg::ref_addr_t'(1);
    ref_push_count  = (ref_count_q < ref_len) ? ref_count_q + khr_pkg::ref_cnt_t'(1) : ref_count_q;

    adv_slot_dec = (adv_slot_q == '0) ? khr_pkg::ref_addr_t'(ref_len - khr_pkg::ref_cnt_t'(1))
                                      : adv_slot_q - khr_pkg::ref_addr_t'(1);
  end

  // age to slot, one compare and subtract each
  always_comb begin
    pos_neg = pos_q[khr_pkg::POS_W-1];
    key_p   = khr_pkg::pos_ext_t'(pos_q);
    if (pos_neg) begin
      key_p = key_p + khr_pkg::pos_ext_t'(key_count_q);
    end
    key_hit = !key_p[khr_pkg::POS_W] &&
              (khr_pkg::upos_t'(key_p) < khr_pkg::upos_t'(key_count_q));
    key_sum = khr_pkg::key_sum_t'(key_newest_q) + khr_pkg::key_sum_t'(key_len)
              - khr_pkg::key_sum_t'(khr_pkg::upos_t'(key_p));
    if (key_sum >= khr_pkg::key_sum_t'(key_len)) begin
      key_sum = key_sum - khr_pkg::key_sum_t'(key_len);
    end
    key_slot = khr_pkg::key_addr_t'(key_sum);

    ref_in  = !pos_neg &&
              (khr_pkg::ref_sum_t'(khr_pkg::upos_t'(pos_q)) < khr_pkg::ref_sum_t'(ref_count_q));
    ref_sum = khr_pkg::ref_sum_t'(ref_newest_q) + khr_pkg::ref_sum_t'(ref_len)
              - khr_pkg::ref_sum_t'(khr_pkg::upos_t'(pos_q));
    if (ref_sum >= khr_pkg::ref_sum_t'(ref_len)) begin
      ref_sum = ref_sum - khr_pkg::ref_sum_t'(ref_len);
    end
    ref_slot = khr_pkg::ref_addr_t'(ref_sum);

    adv_inside  = khr_pkg::ref_sum_t'(adv_idx_q) < khr_pkg::ref_sum_t'(ref_count_q);
    adv_idx_inc = adv_idx_q + khr_pkg::upos_t'(1);
  end

  // status for the controller
  always_comb begin
    stat_o.go_read     = (command_q == khr_pkg::CMD_READ_KEY) ||
                         (command_q == khr_pkg::CMD_READ_REF);
    stat_o.go_pop_walk = (command_q == khr_pkg::CMD_POP_KEY) &&
                         (key_count_q > khr_pkg::key_cnt_t'(1));
    stat_o.go_adv_walk = (command_q == khr_pkg::CMD_ADVANCE) && !pos_neg;
    stat_o.walk_done   = 1'b0;
    if (ctrl_i.pop_step) begin
      stat_o.walk_done = (ref_count_q == '0) || (ref_rd_q == khr_pkg::SEPARATOR);
    end else if (ctrl_i.adv_step) begin
      stat_o.walk_done = !adv_inside || (ref_rd_q == khr_pkg::SEPARATOR);
    end
  end

  // next state of rings, walks and result
  always_comb begin
    key_newest_d = key_newest_q;
    key_count_d  = key_count_q;
    ref_newest_d = ref_newest_q;
    ref_count_d  = ref_count_q;
    adv_idx_d    = adv_idx_q;
    adv_slot_d   = adv_slot_q;
    res_hit_d    = res_hit_q;
    res_code_d   = res_code_q;
    res_flags_d  = res_flags_q;
    res_next_d   = res_next_q;
    key_we       = 1'b0;
    key_waddr    = key_push_newest;
    key_wdata    = {flags_q, code_q};
    key_raddr    = key_slot;
    ref_we       = 1'b0;
    ref_waddr    = ref_push_newest;
    ref_wdata    = code_q;
    ref_raddr    = ref_newest_q;

    // ring reset after power-up or a register write
    if (ctrl_i.init) begin
      key_newest_d = '0;
      key_count_d  = khr_pkg::key_cnt_t'(1);
      ref_newest_d = '0;
      ref_count_d  = khr_pkg::ref_cnt_t'(1);
      key_we       = 1'b1;
      key_waddr    = '0;
      key_wdata    = {khr_pkg::flags_t'(0), khr_pkg::SPACE_CODE};
      ref_we       = 1'b1;
      ref_waddr    = '0;
      ref_wdata    = khr_pkg::SEPARATOR;
    end

    // first step of a command
    if (ctrl_i.exec) begin
      res_hit_d   = 1'b0;
      res_code_d  = '0;
      res_flags_d = '0;
      res_next_d  = '0;
      case (command_q)
        khr_pkg::CMD_RESET, khr_pkg::CMD_POP_KEY: begin
          if (command_q == khr_pkg::CMD_RESET || key_count_q <= khr_pkg::key_cnt_t'(1)) begin
            key_newest_d = '0;
            key_count_d  = khr_pkg::key_cnt_t'(1);
            ref_newest_d = '0;
            ref_count_d  = khr_pkg::ref_cnt_t'(1);
            key_we       = 1'b1;
            key_waddr    = '0;
            key_wdata    = {khr_pkg::flags_t'(0), khr_pkg::SPACE_CODE};
            ref_we       = 1'b1;
            ref_waddr    = '0;
            ref_wdata    = khr_pkg::SEPARATOR;
          end else begin
            // drop the newest key, then walk its reference group
            key_newest_d = key_back_newest;
            key_count_d  = key_count_q - khr_pkg::key_cnt_t'(1);
          end
        end
        khr_pkg::CMD_PUSH_KEY: begin
          key_newest_d = key_push_newest;
          key_count_d  = key_push_count;
          key_we       = 1'b1;
          ref_newest_d = ref_push_newest;
          ref_count_d  = ref_push_count;
          ref_we       = 1'b1;
          ref_wdata    = khr_pkg::SEPARATOR;
        end
        khr_pkg::CMD_PUSH_REF: begin
          ref_newest_d = ref_push_newest;
          ref_count_d  = ref_push_count;
          ref_we       = 1'b1;
        end
        khr_pkg::CMD_READ_KEY: begin
          res_hit_d = key_hit;
        end
        khr_pkg::CMD_READ_REF: begin
          res_hit_d = ref_in;
          ref_raddr = ref_slot;
        end
        khr_pkg::CMD_ADVANCE: begin
          adv_idx_d  = khr_pkg::upos_t'(pos_q);
          adv_slot_d = ref_slot;
          ref_raddr  = ref_slot;
        end
        default: ;
      endcase
    end

    // read data arrives
    if (ctrl_i.read_done && res_hit_q) begin
      if (command_q == khr_pkg::CMD_READ_KEY) begin
        res_code_d  = key_rd_q[khr_pkg::CODE_W-1:0];
        res_flags_d = key_rd_q[khr_pkg::FLAG_W+khr_pkg::CODE_W-1:khr_pkg::CODE_W];
      end else begin
        res_code_d  = ref_rd_q;
      end
    end

    // pop walk: one reference entry per cycle down to the separator
    if (ctrl_i.pop_step && ref_count_q != '0) begin
      ref_newest_d = ref_back_newest;
      ref_count_d  = ref_count_q - khr_pkg::ref_cnt_t'(1);
      ref_raddr    = ref_back_newest;
    end

    // advance walk: one reference entry per cycle up to the separator
    if (ctrl_i.adv_step) begin
      if (adv_inside && ref_rd_q != khr_pkg::SEPARATOR) begin
        adv_idx_d  = adv_idx_inc;
        adv_slot_d = adv_slot_dec;
        ref_raddr  = adv_slot_dec;
      end else begin
        res_next_d = adv_idx_inc;
        res_hit_d  = khr_pkg::ref_sum_t'(adv_idx_inc) < khr_pkg::ref_sum_t'(ref_count_q);
      end
    end
  end

  // ring control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_newest_q <= '0;
      key_count_q  <= khr_pkg::key_cnt_t'(1);
      ref_newest_q <= '0;
      ref_count_q  <= khr_pkg::ref_cnt_t'(1);
    end else begin
      key_newest_q <= key_newest_d;
      key_count_q  <= key_count_d;
      ref_newest_q <= ref_newest_d;
      ref_count_q  <= ref_count_d;
    end
  end

  // item, walk and result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      command_q <= command_i;
      code_q    <= code_in_i;
      flags_q   <= flags_in_i;
      pos_q     <= position_i;
    end
    adv_idx_q   <= adv_idx_d;
    adv_slot_q  <= adv_slot_d;
    res_hit_q   <= res_hit_d;
    res_code_q  <= res_code_d;
    res_flags_q <= res_flags_d;
    res_next_q  <= res_next_d;
    if (ctrl_i.load_out) begin
      hit_o           <= res_hit_q;
      code_out_o      <= res_code_q;
      flags_out_o     <= res_flags_q;
      next_position_o <= res_next_q;
      keys_held_o     <= key_count_q;
      refs_held_o     <= ref_count_q;
    end
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rd_q <= key_mem[key_raddr];
  end

  // reference memory
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    ref_rd_q <= ref_mem[ref_raddr];
  end

`ifndef SYNTH
  a_counts_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.exec |-> key_count_q <= key_len && ref_count_q <= ref_len)
    else $error("ring count above ring length");

  a_newest_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.exec |-> khr_pkg::key_cnt_t'(key_newest_q) < key_len &&
                    khr_pkg::ref_cnt_t'(ref_newest_q) < ref_len)
    else $error("newest pointer outside ring");

  a_pop_step_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop_step && ref_count_q != '0 |=>
      ref_count_q == $past(ref_count_q) - khr_pkg::ref_cnt_t'(1))
    else $error("pop walk did not drop one reference entry");
`endif

endmodule

`default_nettype wire
